@@ sv/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        blk_t words;
        logic final_blk;
    } q_entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_ctl_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

@@ sv/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 hash of a byte stream, digest out as five 32-bit words.
// ----------------------------------------------------------------------------
// Send the message one byte per transaction with tuser high; tlast marks the
// final transaction, which may carry no byte (tuser low) for an empty
// message. Bytes are taken while the packer accumulates; after each 64-byte
// block it holds input off while handing the block to a two-block queue,
// waiting while the queue is full. The compression engine loads a block, runs
// 80 rounds and does the chaining update; sustained throughput is set by the
// one-round-per-cycle engine. At message end padding adds one or two blocks,
// then the digest leaves as five transactions, word 0 first, tlast on word 4.
// ----------------------------------------------------------------------------
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);

    q_ctl_t      q_ctl;
    q_entry_t    push_entry, pop_entry;
    logic        push, pop;
    logic [31:0] out_word;
    logic [2:0]  out_index;

    sha1md_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_last    (s_tlast),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .q_ctl      (q_ctl),
        .push       (push),
        .push_entry (push_entry)
    );

    sha1md_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_ctl      (q_ctl)
    );

    sha1md_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_ctl     (q_ctl),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_word  (out_word),
        .out_index (out_index),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {5'd0, out_index, out_word};

endmodule

@@ sv/sha1md_front.sv @@
// ----------------------------------------------------------------------------
// sha1md_front
// Packs message bytes into 64-byte blocks, appends padding and bit length,
// and hands each block to the queue.
// ----------------------------------------------------------------------------
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_present,
    input  logic       in_last,
    input  logic       in_valid,
    output logic       in_ready,
    input  q_ctl_t     q_ctl,
    output logic       push,
    output q_entry_t   push_entry
);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;
    localparam logic [1:0] ST_ZLEN = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic        endp_reg, endp_next;
    logic        padded_reg, padded_next;
    blk_t        buf_reg, buf_next;
    logic [63:0] len_bits;
    logic [3:0]  wi;
    logic [31:0] cur_word;

    assign len_bits         = {cnt_reg, 3'b000};
    assign wi               = pos_reg[5:2];
    assign cur_word         = buf_reg[wi];
    assign in_ready         = (st_reg == ST_ACC);
    assign push             = (st_reg == ST_PUSH);
    assign push_entry.words = buf_reg;
    assign push_entry.final_blk = fin_reg;

    always_comb
    begin
        st_next     = st_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        endp_next   = endp_reg;
        padded_next = padded_reg;
        buf_next    = buf_reg;
        unique case (st_reg)
            ST_ACC:
            begin
                if (in_valid)
                begin
                    if (in_present)
                    begin
                        case (pos_reg[1:0])
                            2'd0:    buf_next[wi] = {in_byte, 24'd0};
                            2'd1:    buf_next[wi] = {cur_word[31:24], in_byte, 16'd0};
                            2'd2:    buf_next[wi] = {cur_word[31:16], in_byte, 8'd0};
                            default: buf_next[wi] = {cur_word[31:8], in_byte};
                        endcase
                        pos_next = pos_reg + 6'd1;
                        cnt_next = cnt_reg + 61'd1;
                        if (pos_reg == 6'd63)
                        begin
                            st_next   = ST_PUSH;
                            fin_next  = 1'b0;
                            endp_next = in_last;
                        end
                        else if (in_last)
                        begin
                            st_next = ST_PAD;
                        end
                    end
                    else if (in_last)
                    begin
                        st_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) > wi)
                    begin
                        buf_next[i] = 32'd0;
                    end
                end
                case (pos_reg[1:0])
                    2'd0:    buf_next[wi] = {PAD_BYTE, 24'd0};
                    2'd1:    buf_next[wi] = {cur_word[31:24], PAD_BYTE, 16'd0};
                    2'd2:    buf_next[wi] = {cur_word[31:16], PAD_BYTE, 8'd0};
                    default: buf_next[wi] = {cur_word[31:8], PAD_BYTE};
                endcase
                if (pos_reg < 6'd56)
                begin
                    buf_next[14] = len_bits[63:32];
                    buf_next[15] = len_bits[31:0];
                    fin_next     = 1'b1;
                end
                else
                begin
                    fin_next = 1'b0;
                end
                padded_next = 1'b1;
                st_next     = ST_PUSH;
            end
            ST_ZLEN:
            begin
                for (int i = 0; i < 14; i++)
                begin
                    buf_next[i] = 32'd0;
                end
                buf_next[14] = len_bits[63:32];
                buf_next[15] = len_bits[31:0];
                fin_next     = 1'b1;
                st_next      = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!q_ctl.full)
                begin
                    if (fin_reg)
                    begin
                        pos_next    = 6'd0;
                        cnt_next    = 61'd0;
                        padded_next = 1'b0;
                        st_next     = ST_ACC;
                    end
                    else if (padded_reg)
                    begin
                        st_next = ST_ZLEN;
                    end
                    else if (endp_reg)
                    begin
                        endp_next = 1'b0;
                        st_next   = ST_PAD;
                    end
                    else
                    begin
                        st_next = ST_ACC;
                    end
                end
            end
            default:
            begin
                st_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_ACC;
            pos_reg    <= 6'd0;
            cnt_reg    <= 61'd0;
            fin_reg    <= 1'b0;
            endp_reg   <= 1'b0;
            padded_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            endp_reg   <= endp_next;
            padded_reg <= padded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

@@ sv/sha1md_queue.sv @@
// ----------------------------------------------------------------------------
// sha1md_queue
// Two-entry block queue between the packer and the compression engine.
// ----------------------------------------------------------------------------
module sha1md_queue
    import sha1md_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t pop_entry,
    output q_ctl_t   q_ctl
);

    q_entry_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign q_ctl.full  = (cnt_reg == 2'd2);
    assign q_ctl.valid = (cnt_reg != 2'd0);
    assign do_push     = push && !q_ctl.full;
    assign do_pop      = pop && q_ctl.valid;
    assign pop_entry   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/sha1md_core.sv @@
// ----------------------------------------------------------------------------
// sha1md_core
// SHA-1 compression engine, one round per cycle, with chaining update and
// digest word output.
// ----------------------------------------------------------------------------
module sha1md_core
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_ctl_t      q_ctl,
    input  q_entry_t    pop_entry,
    output logic        pop,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last,
    output logic        out_valid,
    input  logic        out_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] v_reg [5];
    logic [31:0] v_next [5];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] fn, kc, tmp, wx;

    assign pop       = (st_reg == ST_IDLE) && q_ctl.valid;
    assign out_valid = (st_reg == ST_OUT);
    assign out_word  = chain_reg[idx_reg];
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 3'd4);

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            fn = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            kc = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            fn = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            kc = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            fn = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            kc = K2;
        end
        else
        begin
            fn = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            kc = K3;
        end
        tmp = {v_reg[0][26:0], v_reg[0][31:27]} + fn + v_reg[4] + kc + win_reg[0];
        wx  = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    end

    always_comb
    begin
        st_next  = st_reg;
        rnd_next = rnd_reg;
        idx_next = idx_reg;
        fin_next = fin_reg;
        chain_next = chain_reg;
        v_next     = v_reg;
        win_next   = win_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_ctl.valid)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        win_next[i] = pop_entry.words[i];
                    end
                    v_next   = chain_reg;
                    fin_next = pop_entry.final_blk;
                    rnd_next = 7'd0;
                    st_next  = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                v_next[4] = v_reg[3];
                v_next[3] = v_reg[2];
                v_next[2] = {v_reg[1][1:0], v_reg[1][31:2]};
                v_next[1] = v_reg[0];
                v_next[0] = tmp;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = {wx[30:0], wx[31]};
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                idx_next = 3'd0;
                st_next  = fin_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'd4)
                    begin
                        chain_next[0] = H0;
                        chain_next[1] = H1;
                        chain_next[2] = H2;
                        chain_next[3] = H3;
                        chain_next[4] = H4;
                        st_next       = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            rnd_reg      <= 7'd0;
            idx_reg      <= 3'd0;
            fin_reg      <= 1'b0;
            chain_reg[0] <= H0;
            chain_reg[1] <= H1;
            chain_reg[2] <= H2;
            chain_reg[3] <= H3;
            chain_reg[4] <= H4;
        end
        else
        begin
            st_reg    <= st_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        win_reg <= win_next;
    end

endmodule
